// ===== design/bounded_stack_with_replace_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounded stack with replace
// Shared concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_STACK_WITH_REPLACE_ASSERT_SVH
`define BOUNDED_STACK_WITH_REPLACE_ASSERT_SVH

// same-cycle implication
`define BSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded stack package
// Operation codes, sequencer states and shared structures.
// ----------------------------------------------------------------------------
`default_nettype none

package bsr_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [2:0] {
    KIND_PUSH    = 3'd0,
    KIND_POP     = 3'd1,
    KIND_PEEK    = 3'd2,
    KIND_CLEAR   = 3'd3,
    KIND_REPLACE = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_CMP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] data;
    logic              is_empty;
    logic              is_full;
  } res_t;

endpackage

`default_nettype wire

// ===== design/bounded_stack_with_replace.sv =====
// Bounded LIFO stack of 32-bit words with push, pop, peek, clear and replace.
// Each operation runs EXEC and then FIN, whose result is loaded into the m_* register;
// pop and peek on a non-empty stack add RDWAIT, replace on one adds CMP once per entry
// compared (one per cycle in the store's read port), for 1 to count entries.
// One item at a time: the next item is taken in the cycle after a result is loaded.
// Reset empties the stack and drops the output; stored words are not cleared.
`default_nettype none

// ----------------------------------------------------------------------------
// Bounded stack with replace
// Top level: stream ports, sequencer, store and output register.
// ----------------------------------------------------------------------------
module bounded_stack_with_replace #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // value[31:0], new_value[63:32]
  input  wire logic [2:0]  s_tuser,  // kind[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,  // data[31:0], is_empty[32], is_full[33], zeros
  output logic      [0:0]  m_tuser   // ok[0]
);
  import bsr_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  res_t              out_res;

  bsr_seq #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_kind     (s_tuser),
    .in_value    (s_tdata[31:0]),
    .in_new_value(s_tdata[63:32]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_ctl     (mem_ctl),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  bsr_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .ctl    (mem_ctl),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {6'b0, out_res.is_full, out_res.is_empty, out_res.data};
  assign m_tuser = out_res.ok;

endmodule

`default_nettype wire

// ===== design/bsr_store.sv =====
// ----------------------------------------------------------------------------
// Stack store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic                      clk,
  input  wire bsr_pkg::mem_ctl_t         ctl,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [bsr_pkg::WORD_W-1:0] wr_data,
  input  wire logic [AW-1:0]             rd_addr,
  output logic      [bsr_pkg::WORD_W-1:0] rd_data
);
  import bsr_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/bsr_seq.sv =====
// ----------------------------------------------------------------------------
// Stack sequencer
// Holds the entry count, runs each operation and scans for replace.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_seq #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [2:0]                 in_kind,
  input  wire logic [bsr_pkg::WORD_W-1:0] in_value,
  input  wire logic [bsr_pkg::WORD_W-1:0] in_new_value,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output bsr_pkg::res_t                   res,
  output bsr_pkg::mem_ctl_t               mem_ctl,
  output logic      [AW-1:0]              wr_addr,
  output logic      [bsr_pkg::WORD_W-1:0] wr_data,
  output logic      [AW-1:0]              rd_addr,
  input  wire logic [bsr_pkg::WORD_W-1:0] rd_data
);
  import bsr_pkg::*;

  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [AW-1:0]     idx, idx_next;
  logic [2:0]        kind, kind_next;
  logic [WORD_W-1:0] value, value_next;
  logic [WORD_W-1:0] new_value, new_value_next;
  logic              ok, ok_next;
  logic [WORD_W-1:0] data, data_next;
  logic              hit;

  assign hit = (rd_data == value);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    kind      <= kind_next;
    value     <= value_next;
    new_value <= new_value_next;
    ok        <= ok_next;
    data      <= data_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    kind_next      = kind;
    value_next     = value;
    new_value_next = new_value;
    ok_next        = ok;
    data_next      = data;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    mem_ctl        = '0;
    wr_addr        = count[AW-1:0];
    wr_data        = value;
    rd_addr        = AW'(count - CW'(1));
    res.ok         = ok;
    res.data       = data;
    res.is_empty   = (count == '0);
    res.is_full    = (count == FULL_COUNT);

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          kind_next      = in_kind;
          value_next     = in_value;
          new_value_next = in_new_value;
          state_next     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ok_next   = 1'b0;
        data_next = '0;
        state_next = ST_FIN;
        case (kind_t'(kind))
          KIND_PUSH: begin
            if (count != FULL_COUNT) begin
              mem_ctl.wr_en = 1'b1;
              count_next    = count + CW'(1);
              ok_next       = 1'b1;
            end
          end
          KIND_POP, KIND_PEEK: begin
            if (count != '0) begin
              mem_ctl.rd_en = 1'b1;
              state_next    = ST_RDWAIT;
            end
          end
          KIND_CLEAR: begin
            count_next = '0;
            ok_next    = 1'b1;
          end
          KIND_REPLACE: begin
            if (count != '0) begin
              mem_ctl.rd_en = 1'b1;
              idx_next      = AW'(count - CW'(1));
              state_next    = ST_CMP;
            end
          end
          default: begin
            state_next = ST_FIN;
          end
        endcase
      end
      ST_RDWAIT: begin
        ok_next   = 1'b1;
        data_next = rd_data;
        if (kind_t'(kind) == KIND_POP) begin
          count_next = count - CW'(1);
        end
        state_next = ST_FIN;
      end
      ST_CMP: begin
        rd_addr = idx - AW'(1);
        wr_addr = idx;
        wr_data = new_value;
        if (hit) begin
          mem_ctl.wr_en = 1'b1;
          ok_next       = 1'b1;
          state_next    = ST_FIN;
        end else if (idx == '0) begin
          state_next = ST_FIN;
        end else begin
          mem_ctl.rd_en = 1'b1;
          idx_next      = idx - AW'(1);
        end
      end
      ST_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`include "bounded_stack_with_replace_assert.svh"

  `BSR_ASSERT_NOW(a_count_bound, 1'b1, count <= FULL_COUNT, "entry count above depth")
  `BSR_ASSERT_NOW(a_scan_in_range, state == ST_CMP, CW'(idx) < count, "scan index past top")
  `BSR_ASSERT_NEXT(a_clear_empties, state == ST_EXEC && kind_t'(kind) == KIND_CLEAR,
                   count == '0, "clear left entries")

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Bounded stack with replace: stream-level testbench
// Drives push, pop, peek, clear, replace and spare codes through the slave
// stream, mirrors the stack in a local model and checks each result word on
// the master stream. Both sides idle at random, and one long hold-off on the
// result side lets the block stall its input.
// ----------------------------------------------------------------------------
module tb_top;
  import bsr_pkg::*;

  localparam int unsigned STACK_DEPTH  = 16;
  localparam logic [2:0]  KIND_SPARE_LO = 3'd5;
  localparam logic [2:0]  KIND_SPARE_HI = 3'd7;
  localparam int unsigned RANDOM_HALF  = 340;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES  = 160;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [0:0]  m_tuser;

  logic [31:0] stack_words [STACK_DEPTH];
  int unsigned live_count;
  res_t        pending_results [$];
  int unsigned error_count;
  int unsigned results_checked;
  int unsigned refused_seen;
  int unsigned kind_sent [8];
  bit          idling_on = 1'b1;
  int unsigned hold_left;

  bounded_stack_with_replace #(
    .DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("bounded_stack_with_replace verification failed");
    $finish;
  end

  function automatic res_t stack_op_result(input logic [2:0] k, input logic [31:0] v,
                                           input logic [31:0] nv);
    res_t r;
    int   i;
    r = '0;
    case (k)
      KIND_PUSH: begin
        if (live_count < STACK_DEPTH) begin
          stack_words[live_count] = v;
          live_count++;
          r.ok = 1'b1;
        end
      end
      KIND_POP: begin
        if (live_count > 0) begin
          live_count--;
          r.data = stack_words[live_count];
          r.ok   = 1'b1;
        end
      end
      KIND_PEEK: begin
        if (live_count > 0) begin
          r.data = stack_words[live_count - 1];
          r.ok   = 1'b1;
        end
      end
      KIND_CLEAR: begin
        live_count = 0;
        r.ok       = 1'b1;
      end
      KIND_REPLACE: begin
        for (i = int'(live_count); i > 0; i--) begin
          if (stack_words[i - 1] == v) begin
            stack_words[i - 1] = nv;
            r.ok = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    r.is_empty = (live_count == 0);
    r.is_full  = (live_count >= STACK_DEPTH);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] pick_word();
    logic [31:0] corners [4];
    int unsigned r;
    corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    r = $urandom_range(0, 9);
    if (r < 2) return corners[$urandom_range(0, 3)];
    if (r < 4) return $urandom_range(0, 3);
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_search_word();
    if (live_count > 0 && $urandom_range(0, 9) < 7)
      return stack_words[$urandom_range(0, live_count - 1)];
    return pick_word();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, want);
  endtask

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic send_op(input logic [2:0] k, input logic [31:0] v, input logic [31:0] nv);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {nv, v};
    do @(posedge clk); while (!s_tready);
    kind_sent[k]++;
    pending_results.push_back(stack_op_result(k, v, nv));
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", m_tdata[31:0], '0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (!want.ok) refused_seen++;
        compare_field("ok", 32'(m_tuser[0]), 32'(want.ok));
        compare_field("data", m_tdata[31:0], want.data);
        compare_field("is_empty", 32'(m_tdata[32]), 32'(want.is_empty));
        compare_field("is_full", 32'(m_tdata[33]), 32'(want.is_full));
        compare_field("padding", 32'(m_tdata[39:34]), '0);
      end
    end
  end

  task automatic test_empty_refusals();
    send_op(KIND_POP, 32'h0, 32'h0);
    send_op(KIND_PEEK, 32'h0, 32'h0);
    send_op(KIND_REPLACE, 32'h0, 32'hFFFF_FFFF);
    send_op(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(KIND_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_fill_to_full();
    logic [31:0] fill [9];
    int unsigned i;
    fill = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555,
             32'hAAAA_AAAA, 32'h0000_0001, 32'h1234_5678, 32'h1234_5678};
    for (i = 0; i < STACK_DEPTH; i++)
      send_op(KIND_PUSH, (i < 9) ? fill[i] : $urandom(), $urandom());
    send_op(KIND_PUSH, 32'hDEAD_BEEF, 32'h0);
    send_op(KIND_PEEK, 32'h0, 32'h0);
  endtask

  task automatic test_replace_cases();
    // duplicate: topmost copy only
    send_op(KIND_REPLACE, 32'h1234_5678, 32'h8000_0000);
    // deep scan towards the bottom
    send_op(KIND_REPLACE, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
    send_op(KIND_REPLACE, 32'hDEAD_BEEF, 32'h0BAD_F00D);
  endtask

  task automatic test_clear_stale();
    send_op(KIND_CLEAR, 32'h0, 32'h0);
    // stale words below the old top must not match
    send_op(KIND_REPLACE, 32'h5555_5555, 32'h0);
  endtask

  task automatic test_random_mix(input int unsigned count);
    int unsigned n;
    int unsigned r;
    int unsigned push_bias;
    logic [2:0]  k;
    push_bias = 50;
    for (n = 0; n < count; n++) begin
      if (n % 60 == 0) push_bias = $urandom_range(20, 72);
      if (n % 150 == 0) idling_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r >= 97) k = KIND_CLEAR;
      else if (r == 96) k = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      else if (r >= 86) k = KIND_REPLACE;
      else if (r < push_bias) k = KIND_PUSH;
      else if ($urandom_range(0, 2) != 0) k = KIND_POP;
      else k = KIND_PEEK;
      send_op(k, (k == KIND_REPLACE) ? pick_search_word() : pick_word(), pick_word());
    end
    idling_on = 1'b1;
  endtask

  task automatic test_backpressure();
    int unsigned n;
    idling_on = 1'b0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    for (n = 0; n < 12; n++)
      send_op(($urandom_range(0, 1) != 0) ? KIND_PUSH : KIND_POP, pick_word(), pick_word());
    idling_on = 1'b1;
  endtask

  initial begin
    live_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_refusals();
    test_fill_to_full();
    test_replace_cases();
    test_clear_stale();
    test_random_mix(RANDOM_HALF);
    test_backpressure();
    test_random_mix(RANDOM_HALF);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered: push %0d, pop %0d, peek %0d, clear %0d, replace %0d, spare codes %0d",
             kind_sent[KIND_PUSH], kind_sent[KIND_POP], kind_sent[KIND_PEEK],
             kind_sent[KIND_CLEAR], kind_sent[KIND_REPLACE],
             kind_sent[5] + kind_sent[6] + kind_sent[7]);
    $display("Checked %0d results (%0d refused or unmatched), %0d mismatches",
             results_checked, refused_seen, error_count);
    if (error_count == 0) begin
      $display("bounded_stack_with_replace verification clean");
    end else begin
      $display("bounded_stack_with_replace verification failed");
    end
    $finish;
  end

endmodule
